// ----- rtl/core/ogi_pkg.sv -----
// shared constants and types for the occupancy grid inflation block
`timescale 1ns / 1ps
`default_nettype none
package ogi_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_MARGIN = 7;

   localparam int CELL_W       = 8;
   localparam int CSR_AW       = 2;
   localparam int CSR_DW       = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MARGIN_REG_W = 3;

   localparam int RST_MAP_WIDTH  = 1024;
   localparam int RST_MAP_HEIGHT = 1024;
   localparam int RST_MARGIN     = 0;

   localparam logic signed [CELL_W-1:0] OBSTACLE = 8'sd100;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_MARGIN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     last_cell;
      logic signed [CELL_W-1:0] cell_out;
   } rsp_beat_type;

endpackage
`default_nettype wire

// ----- rtl/core/ogi_if.sv -----
// stream interfaces for grid cells in and inflated cells out
`timescale 1ns / 1ps
`default_nettype none
interface ogi_req_if import ogi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_in;
   logic                     is_pad;

   modport source (output valid, output cell_in, output is_pad, input ready);
   modport sink (input valid, input cell_in, input is_pad, output ready);
endinterface

interface ogi_rsp_if import ogi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_out;
   logic                     last_cell;

   modport source (output valid, output cell_out, output last_cell, input ready);
   modport sink (input valid, input cell_out, input last_cell, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/occupancy_grid_obstacle_inflation.sv -----
// obstacle inflation of an occupancy grid streamed in raster order
//
// req_bus takes one grid cell per beat, row 0 first, column 0 first; after
// the last cell of the map, pad beats (is_pad) push the remaining results
// out. pads before the end of the map are dropped. rsp_bus gives every cell
// of the map in the same order, 100 where an obstacle lies within
// margin_cells (chebyshev) inside the map, else the original value;
// last_cell marks the final cell, after which the next map may start.
// csr_* writes map_width, map_height and margin_cells while idle; a write
// restarts the stream and holds req ready low for one cycle.
// throughput: one beat per cycle both ways unless the output queue is full
// or a csr write holds req ready low. the result of cell k is released by
// input beat k + margin_cells*map_width + margin_cells, registered with the
// column gap and ring memory reads, then queued with the window update.
// a three entry output queue decouples the sides: when rsp stalls, req
// keeps accepting until the queue and the window stage hold three results.
// reset: synchronous, restores the register defaults and an empty stream;
// memories are not cleared (row 0 ignores stale column gaps).
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_obstacle_inflation import ogi_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_MARGIN = DEF_MAX_MARGIN
) (
   input  wire logic              clock,
   input  wire logic              reset,
   ogi_req_if.sink                req_bus,
   ogi_rsp_if.source              rsp_bus,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int HW      = $clog2(MAX_HEIGHT + 1);
   localparam int VW      = $clog2(MAX_HEIGHT + 2 * MAX_MARGIN + 2);
   localparam int MW      = (MAX_MARGIN > 0) ? $clog2(MAX_MARGIN + 1) : 1;
   localparam int MAX_LAG = MAX_MARGIN * MAX_WIDTH + MAX_MARGIN;
   localparam int LW      = (MAX_LAG > 0) ? $clog2(MAX_LAG + 1) : 1;
   localparam int RING    = 2 ** LW;
   localparam int GW      = $clog2(2 * MAX_MARGIN + 2);
   localparam int WIN     = 2 * MAX_MARGIN + 1;
   localparam int PW      = MW + WW + 1;
   localparam int QD      = 3;

   localparam int RST_W_EFF = (RST_MAP_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_MAP_WIDTH;
   localparam int RST_H_EFF = (RST_MAP_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_MAP_HEIGHT;
   localparam int RST_M_EFF = (RST_MARGIN > MAX_MARGIN) ? MAX_MARGIN : RST_MARGIN;
   localparam int RST_LAG   = RST_M_EFF * RST_W_EFF + RST_M_EFF;

   localparam logic [GW-1:0] GAP_SAT = '1;

   // configuration
   logic [WW-1:0] width_ff,  width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [MW-1:0] margin_ff, margin_in;
   logic [LW-1:0] lag_ff;
   logic          settle_ff;
   logic          cfg_hit;
   logic [PW-1:0] lag_full;

   logic [WIDTH_REG_W-1:0]  raw_w;
   logic [HEIGHT_REG_W-1:0] raw_h;
   logic [MARGIN_REG_W-1:0] raw_m;

   // stream position
   logic [CW-1:0] vx_ff, vx_in;
   logic [VW-1:0] vy_ff, vy_in;
   logic [LW-1:0] pre_ff, pre_in;
   logic [CW-1:0] ox_ff, ox_in;
   logic [HW-1:0] oy_ff, oy_in;
   logic [LW-1:0] wp_ff, wp_in;
   logic [LW-1:0] rp;

   logic accept, done, counted, real_cell, emit, last_out, frame_end;
   logic vx_wrap, ox_wrap;
   logic [WIN-1:0] mask;

   // memories
   logic [CELL_W-1:0] pend_mem [RING];
   logic [GW-1:0]     gap_mem  [MAX_WIDTH];
   logic [CELL_W-1:0] pend_rd_ff;
   logic [GW-1:0]     gap_rd_ff;

   // window stage
   logic           s1_valid_ff;
   logic [CW-1:0]  s1_x_ff;
   logic           s1_row0_ff;
   logic           s1_obst_ff;
   logic           s1_emit_ff;
   logic           s1_last_ff;
   logic [WIN-1:0] s1_mask_ff;
   logic [WIN-1:0] win_ff;
   logic [WIN-1:0] win_next;
   logic [GW-1:0]  gap_old, gap_new;
   logic           vflag, near;
   rsp_beat_type   s1_beat;

   // output queue
   rsp_beat_type q_mem [QD];
   logic [1:0]   q_wp_ff, q_rp_ff, q_cnt_ff;
   logic         push, pop;

   // ---------------- configuration ----------------
   assign raw_w   = csr_wdata[WIDTH_REG_W-1:0];
   assign raw_h   = csr_wdata[HEIGHT_REG_W-1:0];
   assign raw_m   = csr_wdata[MARGIN_REG_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      margin_in = margin_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH: begin
               cfg_hit = 1'b1;
               if (raw_w == '0) width_in = WW'(1);
               else if (int'(raw_w) > MAX_WIDTH) width_in = WW'(MAX_WIDTH);
               else width_in = WW'(raw_w);
            end
            CSR_MAP_HEIGHT: begin
               cfg_hit = 1'b1;
               if (raw_h == '0) height_in = HW'(1);
               else if (int'(raw_h) > MAX_HEIGHT) height_in = HW'(MAX_HEIGHT);
               else height_in = HW'(raw_h);
            end
            CSR_MARGIN: begin
               cfg_hit = 1'b1;
               if (int'(raw_m) > MAX_MARGIN) margin_in = MW'(MAX_MARGIN);
               else margin_in = MW'(raw_m);
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   assign lag_full = PW'(margin_ff) * PW'(width_ff) + PW'(margin_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RST_W_EFF);
         height_ff <= HW'(RST_H_EFF);
         margin_ff <= MW'(RST_M_EFF);
         lag_ff    <= LW'(RST_LAG);
         settle_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         margin_ff <= margin_in;
         lag_ff    <= LW'(lag_full);
         settle_ff <= cfg_hit;
      end
   end

   // ---------------- input side ----------------
   assign req_bus.ready = !settle_ff &&
                          ((3'(q_cnt_ff) + 3'(s1_valid_ff & s1_emit_ff)) < 3'(QD));
   assign accept    = req_bus.valid && req_bus.ready;
   assign done      = (vy_ff >= VW'(height_ff));
   assign counted   = accept && (done || !req_bus.is_pad);
   assign real_cell = accept && !done && !req_bus.is_pad;
   assign emit      = counted && (pre_ff == lag_ff);
   assign vx_wrap   = (WW'(vx_ff) == width_ff - WW'(1));
   assign ox_wrap   = (WW'(ox_ff) == width_ff - WW'(1));
   assign last_out  = ox_wrap && (oy_ff == height_ff - HW'(1));
   assign frame_end = emit && last_out;
   assign rp        = wp_ff - lag_ff;

   always_comb begin
      vx_in  = vx_ff;
      vy_in  = vy_ff;
      pre_in = pre_ff;
      ox_in  = ox_ff;
      oy_in  = oy_ff;
      wp_in  = wp_ff;
      if (cfg_hit || frame_end) begin
         vx_in  = '0;
         vy_in  = '0;
         pre_in = '0;
         ox_in  = '0;
         oy_in  = '0;
         wp_in  = '0;
      end else if (counted) begin
         wp_in = wp_ff + LW'(1);
         if (vx_wrap) begin
            vx_in = '0;
            vy_in = vy_ff + VW'(1);
         end else begin
            vx_in = vx_ff + CW'(1);
         end
         if (!emit) pre_in = pre_ff + LW'(1);
         if (emit) begin
            if (ox_wrap) begin
               ox_in = '0;
               oy_in = oy_ff + HW'(1);
            end else begin
               ox_in = ox_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff  <= '0;
         vy_ff  <= '0;
         pre_ff <= '0;
         ox_ff  <= '0;
         oy_ff  <= '0;
         wp_ff  <= '0;
      end else begin
         vx_ff  <= vx_in;
         vy_ff  <= vy_in;
         pre_ff <= pre_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         wp_ff  <= wp_in;
      end
   end

   // columns of the current output row that the window may use
   always_comb begin
      int mm;
      int xl;
      int xr;
      mm = int'(margin_ff);
      xl = int'(ox_ff);
      xr = int'(width_ff) - 1 - int'(ox_ff);
      for (int d = 0; d < WIN; d++) begin
         if (d <= mm) mask[d] = ((mm - d) <= xr);
         else mask[d] = (d <= 2 * mm) && ((d - mm) <= xl);
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (real_cell) pend_mem[wp_ff] <= req_bus.cell_in;
      if (counted) begin
         if (real_cell && rp == wp_ff) pend_rd_ff <= req_bus.cell_in;
         else pend_rd_ff <= pend_mem[rp];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) gap_mem[s1_x_ff] <= gap_new;
      if (counted) begin
         if (s1_valid_ff && s1_x_ff == vx_ff) gap_rd_ff <= gap_new;
         else gap_rd_ff <= gap_mem[vx_ff];
      end
   end

   // ---------------- window stage ----------------
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= counted;
   end

   always_ff @(posedge clock) begin
      if (counted) begin
         s1_x_ff    <= vx_ff;
         s1_row0_ff <= (vy_ff == '0);
         s1_obst_ff <= real_cell && (req_bus.cell_in == OBSTACLE);
         s1_emit_ff <= emit;
         s1_last_ff <= last_out;
         s1_mask_ff <= mask;
      end
      if (s1_valid_ff) win_ff <= win_next;
   end

   // rows since the last obstacle in this column, saturating
   always_comb begin
      gap_old = s1_row0_ff ? GAP_SAT : gap_rd_ff;
      if (s1_obst_ff) gap_new = '0;
      else if (gap_old == GAP_SAT) gap_new = GAP_SAT;
      else gap_new = gap_old + GW'(1);
      vflag            = (int'(gap_new) <= 2 * int'(margin_ff));
      win_next         = WIN'({win_ff, vflag});
      near             = |(win_next & s1_mask_ff);
      s1_beat.last_cell = s1_last_ff;
      s1_beat.cell_out  = near ? OBSTACLE : $signed(pend_rd_ff);
   end

   // ---------------- output queue ----------------
   assign push = s1_valid_ff && s1_emit_ff;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (push) q_mem[q_wp_ff] <= s1_beat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= '0;
         q_rp_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (push) q_wp_ff <= (q_wp_ff == 2'(QD - 1)) ? 2'd0 : q_wp_ff + 2'd1;
         if (pop) q_rp_ff <= (q_rp_ff == 2'(QD - 1)) ? 2'd0 : q_rp_ff + 2'd1;
         if (push && !pop) q_cnt_ff <= q_cnt_ff + 2'd1;
         else if (pop && !push) q_cnt_ff <= q_cnt_ff - 2'd1;
      end
   end

   assign rsp_bus.valid     = (q_cnt_ff != 2'd0);
   assign rsp_bus.cell_out  = q_mem[q_rp_ff].cell_out;
   assign rsp_bus.last_cell = q_mem[q_rp_ff].last_cell;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking testbench for the occupancy grid obstacle inflation block
`timescale 1ns / 1ps
module tb;
   import ogi_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   ogi_req_if req_bus ();
   ogi_rsp_if rsp_bus ();

   occupancy_grid_obstacle_inflation dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.cell_in = '0;
      req_bus.is_pad = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   // predictor state
   int unsigned map_w_reg = RST_MAP_WIDTH;
   int unsigned map_h_reg = RST_MAP_HEIGHT;
   int unsigned margin_reg = RST_MARGIN;
   int unsigned col_pos, row_pos, beats_taken, out_idx;
   logic signed [CELL_W-1:0] frame_cells [int];
   rsp_beat_type inflated_cells [$];

   int tx_gap_pct = 15;
   int rx_gap_pct = 47;
   int hold_request = 0;
   bit failed = 1'b0;

   function automatic int unsigned grid_w();
      if (map_w_reg == 0) return 1;
      return (map_w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : map_w_reg;
   endfunction

   function automatic int unsigned grid_h();
      if (map_h_reg == 0) return 1;
      return (map_h_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : map_h_reg;
   endfunction

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      beats_taken = 0;
      out_idx = 0;
      frame_cells.delete();
   endfunction

   function automatic void apply_csr(csr_index_type idx, int unsigned value);
      case (idx)
         CSR_MAP_WIDTH: map_w_reg = value & 'h7FF;
         CSR_MAP_HEIGHT: map_h_reg = value & 'h1FFF;
         CSR_MARGIN: margin_reg = value & 'h7;
         default: return;
      endcase
      restart_frame();
   endfunction

   function automatic bit frame_busy();
      return (row_pos != 0) || (col_pos != 0) || (beats_taken != 0);
   endfunction

   // one accepted beat in, at most one inflated cell out
   function automatic bit inflate_step(logic signed [CELL_W-1:0] cell_val, bit pad,
                                       output rsp_beat_type r);
      int unsigned w, h, m, total, lag;
      int x0, y0, nx, ny;
      bit near;
      w = grid_w();
      h = grid_h();
      m = margin_reg;
      total = w * h;
      lag = m * w + m;
      r = '0;
      if (row_pos < h && !pad) begin
         frame_cells[row_pos * w + col_pos] = cell_val;
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         beats_taken++;
      end else if (row_pos >= h) begin
         beats_taken++;
      end else begin
         return 1'b0;
      end
      if (out_idx >= total || beats_taken < out_idx + lag + 1) return 1'b0;
      x0 = out_idx % w;
      y0 = out_idx / w;
      near = 1'b0;
      for (int dy = -int'(m); dy <= int'(m); dy++) begin
         ny = y0 + dy;
         if (ny < 0 || ny >= int'(h)) continue;
         for (int dx = -int'(m); dx <= int'(m); dx++) begin
            nx = x0 + dx;
            if (nx < 0 || nx >= int'(w)) continue;
            if (frame_cells[ny * w + nx] == OBSTACLE) near = 1'b1;
         end
      end
      r.cell_out = near ? OBSTACLE : frame_cells[out_idx];
      r.last_cell = (out_idx == total - 1);
      out_idx++;
      if (out_idx >= total) restart_frame();
      return 1'b1;
   endfunction

   task automatic send_beat(logic signed [CELL_W-1:0] cell_val, bit pad,
                            bit typed = 1'b0, rsp_beat_type want = '0);
      rsp_beat_type r;
      bit got;
      if ($urandom_range(99) < tx_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cell_in <= cell_val;
      req_bus.is_pad <= pad;
      do @(posedge clock); while (!req_bus.ready);
      got = inflate_step(cell_val, pad, r);
      if (got) inflated_cells = {inflated_cells, (typed ? want : r)};
   endtask

   // sender stops until every expected beat has come back
   task automatic drain(int settle);
      req_bus.valid <= 1'b0;
      while (inflated_cells.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DW'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(idx, value);
   endtask

   function automatic logic signed [CELL_W-1:0] random_cell();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12) return OBSTACLE;
      if (pick < 30) return -8'sd1;
      if (pick < 55) return 8'sd0;
      return CELL_W'($urandom_range(255));
   endfunction

   task automatic send_frame();
      int unsigned cells;
      cells = grid_w() * grid_h();
      for (int unsigned k = 0; k < cells; k++) begin
         // stray pad inside the frame is dropped by the block
         if ($urandom_range(99) < 4) send_beat(CELL_W'($urandom_range(255)), 1'b1);
         send_beat(random_cell(), 1'b0);
      end
      // flush: mostly pads, some cells that count as pads
      while (frame_busy())
         send_beat(CELL_W'($urandom_range(255)), ($urandom_range(99) < 80));
   endtask

   // receiver: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (inflated_cells.size() == 0) begin
               $error("unexpected beat cell_out=%0d last_cell=%0b",
                      rsp_bus.cell_out, rsp_bus.last_cell);
               failed = 1'b1;
            end else begin
               rsp_beat_type want;
               want = inflated_cells.pop_front();
               if (rsp_bus.cell_out !== want.cell_out) begin
                  $error("cell_out expected %0d actual %0d", want.cell_out,
                         rsp_bus.cell_out);
                  failed = 1'b1;
               end
               if (rsp_bus.last_cell !== want.last_cell) begin
                  $error("last_cell expected %0b actual %0b", want.last_cell,
                         rsp_bus.last_cell);
                  failed = 1'b1;
               end
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_gap_pct);
         end
      end
   end

   typedef struct {
      bit is_csr;
      csr_index_type idx;
      int unsigned data;
      logic signed [CELL_W-1:0] cell_val;
      bit pad;
      bit typed;
      logic signed [CELL_W-1:0] want_cell;
      bit want_last;
   } stim_row_type;

   stim_row_type directed [20] = '{
      // reset settings, no margin: every cell comes straight back
      '{0, CSR_MAP_WIDTH, 0, -8'sd128, 0, 1, -8'sd128, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd127, 0, 1, 8'sd127, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd100, 0, 1, 8'sd100, 0},
      '{0, CSR_MAP_WIDTH, 0, -8'sd1, 0, 1, -8'sd1, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd0, 0, 1, 8'sd0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd5, 1, 0, 8'sd0, 0},
      // 3x2 map, margin 1
      '{1, CSR_MAP_WIDTH, 3, 0, 0, 0, 0, 0},
      '{1, CSR_MAP_HEIGHT, 2, 0, 0, 0, 0, 0},
      '{1, CSR_MARGIN, 1, 0, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd100, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, -8'sd128, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd127, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd9, 1, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, -8'sd1, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd0, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd99, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd55, 0, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd0, 1, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, 8'sd100, 1, 0, 0, 0},
      '{0, CSR_MAP_WIDTH, 0, -8'sd7, 0, 0, 0, 0}
   };

   // width, height, margin per phase; zero width or height acts as 1
   int unsigned phase_cfg [12][3] = '{
      '{5, 4, 2}, '{0, 3, 1}, '{16, 9, 3}, '{7, 6, 7}, '{1, 1, 0},
      '{3, 0, 1}, '{8, 8, 4}, '{9, 1, 2}, '{40, 8, 0}, '{4, 12, 1},
      '{10, 7, 5}, '{3, 3, 7}
   };

   initial begin
      rsp_beat_type want;
      int frames;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      restart_frame();

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            drain(8);
            write_csr(directed[i].idx, directed[i].data);
         end else begin
            want.cell_out = directed[i].want_cell;
            want.last_cell = directed[i].want_last;
            send_beat(directed[i].cell_val, directed[i].pad, directed[i].typed, want);
         end
      end

      foreach (phase_cfg[p]) begin
         if (p == 4) begin
            tx_gap_pct = 47;
            rx_gap_pct = 15;
         end else if (p == 8) begin
            tx_gap_pct = 0;
            rx_gap_pct = 0;
         end
         drain(8);
         write_csr(CSR_MAP_WIDTH, phase_cfg[p][0]);
         write_csr(CSR_MAP_HEIGHT, phase_cfg[p][1]);
         write_csr(CSR_MARGIN, phase_cfg[p][2]);
         frames = (grid_w() * grid_h() > 100) ? 1 : 2;
         for (int f = 0; f < frames; f++) begin
            if (p == 2 && f == 0) hold_request = 300;
            if (p == 6 && f == 1) drain(0);
            send_frame();
         end
      end

      drain(20);
      if (!failed) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule
